[src/wfe_pkg.sv]
// Shared types and constants for the WEP frame encapsulator.
// No dependencies; the top level, front and back use this package by scoped names.

package wfe_pkg;

    // Sizes
    localparam int KEYSTREAM_DEPTH_DEF = 2048;
    localparam int HEADER_BYTES        = 24;
    localparam int IV_BYTES            = 4;
    localparam int ICV_BYTES           = 4;
    localparam int POS_W               = 12;
    localparam int KIDX_W              = 12;
    localparam int KEYIN_W             = 11;
    localparam int ADDR_W              = 48;
    localparam int KLEN_W              = 12;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 48;
    localparam int OPQ_DEPTH           = 4;
    localparam int OUTQ_DEPTH          = 4;

    // Frame control byte 1 handling
    localparam logic [7:0] FC_KEEP_MASK = 8'hFC;
    localparam logic [7:0] FC_WEP_SET   = 8'h40;
    localparam logic [7:0] FC_WEP_CLR   = 8'hBF;
    localparam logic [1:0] DS_MASK      = 2'h3;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BSSID = 3'd0,
        CFG_DEST  = 3'd1,
        CFG_SRC   = 3'd2,
        CFG_DS    = 3'd3,
        CFG_ENC   = 3'd4,
        CFG_KLEN  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] bssid;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] src;
        logic [1:0]        ds;
        logic              enc;
        logic [KLEN_W-1:0] klen;
    } cfg_t;

    // Operations passed from front to back
    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,   // keystream store write, no output
        OP_PLAIN = 3'd1,   // send data as is
        OP_KEY   = 3'd2,   // send stored keystream byte (IV)
        OP_BODY  = 3'd3,   // send data XOR keystream, update CRC
        OP_ICV   = 3'd4    // send ICV byte XOR keystream
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [7:0]        data;
        logic [KIDX_W-1:0] addr;
        logic [1:0]        sel;
        logic              last;
        logic              flag_set;
    } op_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
    } out_t;

endpackage

[src/wep_frame_encapsulator.sv]
// WEP frame encapsulator: one byte per cycle through the frame body when not
// stalled; a byte passes the front stage, operation queue, back-end stage and
// result queue. Byte 23 with IV insertion expands into itself and IV bytes,
// input held off meanwhile; a last byte adds the ICV bytes. The front issues
// one operation per cycle unless its queue is full. Reset (rst_n, async)
// clears queues and frame state; config returns to defaults; keystream is kept.

module wep_frame_encapsulator #(
    parameter int KEYSTREAM_DEPTH = wfe_pkg::KEYSTREAM_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              push,
    output logic                              full,
    input  logic                              cmd,
    input  logic [7:0]                        data_byte,
    input  logic [wfe_pkg::KEYIN_W-1:0]       key_index,
    input  logic                              last_byte,
    // result words
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        out_byte,
    output logic                              out_last,
    output logic                              status,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int OPW = $bits(wfe_pkg::op_t);
    localparam int OUW = $bits(wfe_pkg::out_t);

    wfe_pkg::cfg_t  cfg_reg;
    logic           q_push;
    wfe_pkg::op_t   q_wop;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic [OPW-1:0] q_rdata;
    logic           oq_push;
    wfe_pkg::out_t  oq_wdata;
    logic [OUW-1:0] oq_rdata;
    wfe_pkg::out_t  oq_word;
    logic [$clog2(wfe_pkg::OUTQ_DEPTH+1)-1:0] oq_count;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bssid <= '0;
            cfg_reg.dest  <= '0;
            cfg_reg.src   <= '0;
            cfg_reg.ds    <= 2'd1;
            cfg_reg.enc   <= 1'b1;
            cfg_reg.klen  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (wfe_pkg::cfg_idx_t'(cfg_index))
                wfe_pkg::CFG_BSSID: cfg_reg.bssid <= cfg_data[wfe_pkg::ADDR_W-1:0];
                wfe_pkg::CFG_DEST:  cfg_reg.dest  <= cfg_data[wfe_pkg::ADDR_W-1:0];
                wfe_pkg::CFG_SRC:   cfg_reg.src   <= cfg_data[wfe_pkg::ADDR_W-1:0];
                wfe_pkg::CFG_DS:    cfg_reg.ds    <= cfg_data[1:0];
                wfe_pkg::CFG_ENC:   cfg_reg.enc   <= cfg_data[0];
                wfe_pkg::CFG_KLEN:  cfg_reg.klen  <= cfg_data[wfe_pkg::KLEN_W-1:0];
                default:            cfg_reg.enc   <= cfg_reg.enc;
            endcase
        end
    end

    wfe_front #(
        .KEYSTREAM_DEPTH (KEYSTREAM_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .data_byte (data_byte),
        .key_index (key_index),
        .last_byte (last_byte),
        .cfg       (cfg_reg),
        .q_push    (q_push),
        .q_op      (q_wop),
        .q_full    (q_full)
    );

    // Operation queue between front and back
    wfe_fifo #(
        .WIDTH (OPW),
        .DEPTH (wfe_pkg::OPQ_DEPTH)
    ) u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wop),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count ()
    );

    wfe_back #(
        .KEYSTREAM_DEPTH (KEYSTREAM_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_op     (wfe_pkg::op_t'(q_rdata)),
        .oq_push  (oq_push),
        .oq_data  (oq_wdata),
        .oq_count (oq_count)
    );

    // Result queue
    wfe_fifo #(
        .WIDTH (OUW),
        .DEPTH (wfe_pkg::OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty),
        .count (oq_count)
    );

    assign oq_word  = wfe_pkg::out_t'(oq_rdata);
    assign out_byte = oq_word.data;
    assign out_last = oq_word.last;
    assign status   = oq_word.status;

endmodule

[src/wfe_fifo.sv]
// Small first-in first-out queue held in flip-flops.
// Generic: carries any packed word; no package dependency.

module wfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/wfe_front.sv]
// Front end: accepts input words, rewrites header bytes and expands each word
// into one or more operations for the back end. Depends on wfe_pkg.

module wfe_front #(
    parameter int KEYSTREAM_DEPTH = wfe_pkg::KEYSTREAM_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic [7:0]                    data_byte,
    input  logic [wfe_pkg::KEYIN_W-1:0]   key_index,
    input  logic                          last_byte,
    input  wfe_pkg::cfg_t                 cfg,
    output logic                          q_push,
    output wfe_pkg::op_t                  q_op,
    input  logic                          q_full
);

    localparam int PW = wfe_pkg::POS_W;
    localparam int KW = wfe_pkg::KIDX_W;
    localparam logic [PW-1:0] POS_MAX   = '1;
    localparam logic [PW-1:0] HDR_LAST  = PW'(wfe_pkg::HEADER_BYTES - 1);
    localparam logic [PW-1:0] BODY_OFF  = PW'(wfe_pkg::HEADER_BYTES - wfe_pkg::IV_BYTES);
    localparam logic [PW-1:0] ICV_OFF   = PW'(wfe_pkg::HEADER_BYTES - wfe_pkg::IV_BYTES - 1);
    localparam logic [3:0]    N_IV      = 4'(wfe_pkg::IV_BYTES);
    localparam logic [3:0]    N_IV_ICV  = 4'(wfe_pkg::IV_BYTES + wfe_pkg::ICV_BYTES);
    localparam logic [3:0]    N_ICV     = 4'(wfe_pkg::ICV_BYTES);

    typedef enum logic [1:0] {
        IT_WRITE,
        IT_PLAIN,
        IT_HDR,
        IT_BODY
    } item_t;

    // Address field offsets by DS bits
    function automatic logic [4:0] bssid_off(input logic [1:0] ds);
        case (ds)
            2'd0:    return 5'd16;
            2'd1:    return 5'd4;
            2'd2:    return 5'd10;
            default: return 5'd4;
        endcase
    endfunction

    function automatic logic [4:0] dest_off(input logic [1:0] ds);
        case (ds)
            2'd0:    return 5'd4;
            2'd1:    return 5'd16;
            2'd2:    return 5'd4;
            default: return 5'd16;
        endcase
    endfunction

    function automatic logic [4:0] src_off(input logic [1:0] ds);
        case (ds)
            2'd0:    return 5'd10;
            2'd1:    return 5'd10;
            2'd2:    return 5'd16;
            default: return 5'd24;
        endcase
    endfunction

    // Replace with the address byte when pos lies in the field and addr is nonzero
    function automatic logic [7:0] put_addr(
        input logic [7:0]                  v,
        input logic [PW-1:0]               pos,
        input logic [4:0]                  off,
        input logic [wfe_pkg::ADDR_W-1:0]  addr
    );
        logic [PW-1:0] diff;
        logic [2:0]    idx;
        diff = pos - PW'(off);
        idx  = 3'(3'd5 - diff[2:0]);
        if ((addr != '0) && (pos >= PW'(off)) && (diff < PW'(6)))
        begin
            return addr[{idx, 3'b000} +: 8];
        end
        return v;
    endfunction

    function automatic logic in_range(
        input logic [KW-1:0]                idx,
        input logic [wfe_pkg::KLEN_W-1:0]   klen
    );
        return (idx < klen) && ({1'b0, idx} < (KW + 1)'(KEYSTREAM_DEPTH));
    endfunction

    logic [PW-1:0]   pos_reg;
    logic            stg_valid_reg;
    item_t           kind_reg;
    logic [7:0]      v_reg;
    logic [wfe_pkg::KEYIN_W-1:0] ki_reg;
    logic [PW-1:0]   pos_s_reg;
    logic            lb_reg;
    logic            flag_reg;
    logic [3:0]      step_reg;
    logic [3:0]      nlast_reg;

    logic            accept;
    logic            fire;
    logic            done;
    logic [7:0]      v_comb;
    item_t           kind_next;
    logic [3:0]      nlast_next;
    logic            load;
    logic [1:0]      icv_j;
    logic [KW-1:0]   icv_idx;
    logic [KW-1:0]   body_idx;
    wfe_pkg::op_t    op;

    assign fire   = stg_valid_reg && !q_full;
    assign done   = fire && (step_reg == nlast_reg);
    assign full   = stg_valid_reg && !done;
    assign accept = push && !full;
    assign q_push = fire;
    assign q_op   = op;

    // Header rewrite of the incoming byte
    always_comb
    begin
        v_comb = data_byte;
        if (pos_reg == PW'(1))
        begin
            v_comb = (v_comb & wfe_pkg::FC_KEEP_MASK) | {6'b0, cfg.ds & wfe_pkg::DS_MASK};
            v_comb = cfg.enc ? (v_comb | wfe_pkg::FC_WEP_SET) : (v_comb & wfe_pkg::FC_WEP_CLR);
        end
        v_comb = put_addr(v_comb, pos_reg, bssid_off(cfg.ds), cfg.bssid);
        v_comb = put_addr(v_comb, pos_reg, dest_off(cfg.ds), cfg.dest);
        v_comb = put_addr(v_comb, pos_reg, src_off(cfg.ds), cfg.src);
    end

    // Classify the incoming word
    always_comb
    begin
        kind_next  = IT_PLAIN;
        nlast_next = '0;
        load       = 1'b1;
        if (cmd)
        begin
            kind_next = IT_WRITE;
            load      = ({2'b00, key_index} < (KW + 1)'(KEYSTREAM_DEPTH));
        end
        else if (!cfg.enc || (pos_reg < HDR_LAST))
        begin
            kind_next = IT_PLAIN;
        end
        else if (pos_reg == HDR_LAST)
        begin
            kind_next  = IT_HDR;
            nlast_next = last_byte ? N_IV_ICV : N_IV;
        end
        else
        begin
            kind_next  = IT_BODY;
            nlast_next = last_byte ? N_ICV : 4'd0;
        end
    end

    // Operation for the current expansion step
    always_comb
    begin
        icv_j    = (kind_reg == IT_HDR) ? 2'(step_reg - N_IV - 4'd1) : 2'(step_reg - 4'd1);
        icv_idx  = (pos_s_reg - ICV_OFF) + KW'(icv_j);
        body_idx = pos_s_reg - BODY_OFF;
        op          = '0;
        op.kind     = wfe_pkg::OP_PLAIN;
        op.data     = v_reg;
        case (kind_reg)
            IT_WRITE:
            begin
                op.kind = wfe_pkg::OP_WRITE;
                op.addr = KW'(ki_reg);
            end
            IT_PLAIN:
            begin
                op.last     = lb_reg;
                op.flag_set = flag_reg;
            end
            IT_HDR:
            begin
                if (step_reg == 4'd0)
                begin
                    op.kind = wfe_pkg::OP_PLAIN;
                end
                else if (step_reg <= N_IV)
                begin
                    op.kind = wfe_pkg::OP_KEY;
                    op.addr = KW'(step_reg - 4'd1);
                end
                else
                begin
                    op.kind     = wfe_pkg::OP_ICV;
                    op.addr     = icv_idx;
                    op.sel      = icv_j;
                    op.last     = (icv_j == 2'd3);
                    op.flag_set = !in_range(icv_idx, cfg.klen);
                end
            end
            IT_BODY:
            begin
                if (step_reg == 4'd0)
                begin
                    op.kind     = wfe_pkg::OP_BODY;
                    op.addr     = body_idx;
                    op.flag_set = !in_range(body_idx, cfg.klen);
                end
                else
                begin
                    op.kind     = wfe_pkg::OP_ICV;
                    op.addr     = icv_idx;
                    op.sel      = icv_j;
                    op.last     = (icv_j == 2'd3);
                    op.flag_set = !in_range(icv_idx, cfg.klen);
                end
            end
            default:
            begin
                op.kind = wfe_pkg::OP_PLAIN;
            end
        endcase
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_next;
            v_reg     <= cmd ? data_byte : v_comb;
            ki_reg    <= key_index;
            pos_s_reg <= pos_reg;
            lb_reg    <= last_byte;
            flag_reg  <= cfg.enc && last_byte && (pos_reg < HDR_LAST);
            nlast_reg <= nlast_next;
        end
    end

    // Stage control and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            step_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= load;
                step_reg      <= '0;
            end
            else if (done)
            begin
                stg_valid_reg <= 1'b0;
            end
            else if (fire)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (accept && !cmd)
            begin
                if (last_byte)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

endmodule

[src/wfe_back.sv]
// Back end: keystream memory, CRC-32 ICV and the short keystream flag.
// Executes operations in order and feeds the result queue. Depends on wfe_pkg.

module wfe_back #(
    parameter int KEYSTREAM_DEPTH = wfe_pkg::KEYSTREAM_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_empty,
    output logic                                      q_pop,
    input  wfe_pkg::op_t                              q_op,
    output logic                                      oq_push,
    output wfe_pkg::out_t                             oq_data,
    input  logic [$clog2(wfe_pkg::OUTQ_DEPTH+1)-1:0]  oq_count
);

    localparam int AW = $clog2(KEYSTREAM_DEPTH);
    localparam int CW = $clog2(wfe_pkg::OUTQ_DEPTH + 1);

    // One byte of the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ wfe_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]    mem [KEYSTREAM_DEPTH];
    logic [7:0]    rd_reg;
    logic          b_valid_reg;
    wfe_pkg::op_t  b_op_reg;
    logic [31:0]   crc_reg;
    logic          flag_reg;

    logic          flag_now;
    logic [7:0]    key;
    logic [31:0]   icv;
    logic [7:0]    icv_b;
    logic [31:0]   crc_next;

    // Issue only when the result queue has room for everything in flight
    assign q_pop = !q_empty &&
                   (({1'b0, oq_count} + (CW + 1)'(b_valid_reg)) < (CW + 1)'(wfe_pkg::OUTQ_DEPTH));

    // Keystream store: write or registered read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_op.kind == wfe_pkg::OP_WRITE)
            begin
                mem[q_op.addr[AW-1:0]] <= q_op.data;
            end
            rd_reg   <= mem[q_op.addr[AW-1:0]];
            b_op_reg <= q_op;
        end
    end

    // Result word
    always_comb
    begin
        flag_now     = flag_reg | b_op_reg.flag_set;
        key          = b_op_reg.flag_set ? 8'h00 : rd_reg;
        icv          = ~crc_reg;
        icv_b        = icv[{b_op_reg.sel, 3'b000} +: 8];
        crc_next     = crc_reg;
        oq_data.last   = b_op_reg.last;
        oq_data.status = flag_now;
        oq_data.data   = b_op_reg.data;
        case (b_op_reg.kind)
            wfe_pkg::OP_PLAIN: oq_data.data = b_op_reg.data;
            wfe_pkg::OP_KEY:   oq_data.data = rd_reg;
            wfe_pkg::OP_BODY:
            begin
                oq_data.data = b_op_reg.data ^ key;
                crc_next     = crc_byte(crc_reg, b_op_reg.data);
            end
            wfe_pkg::OP_ICV:   oq_data.data = icv_b ^ key;
            default:           oq_data.data = b_op_reg.data;
        endcase
    end

    assign oq_push = b_valid_reg && (b_op_reg.kind != wfe_pkg::OP_WRITE);

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            crc_reg     <= wfe_pkg::CRC_INIT;
            flag_reg    <= 1'b0;
        end
        else
        begin
            b_valid_reg <= q_pop;
            if (oq_push)
            begin
                if (b_op_reg.last)
                begin
                    crc_reg  <= wfe_pkg::CRC_INIT;
                    flag_reg <= 1'b0;
                end
                else
                begin
                    crc_reg  <= crc_next;
                    flag_reg <= flag_now;
                end
            end
        end
    end

endmodule

[src/wfe_checker.sv]
// Port-level checks for the WEP frame encapsulator, bound to the top level.
// Depends only on the top level's ports.

module wfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       cmd,
    input logic       last_byte,
    input logic       pop,
    input logic       empty,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       status
);

    logic       in_acc;
    logic       out_acc;
    logic       bad_reg;
    logic [7:0] frames_reg;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // Discard verdict seen so far in the current output frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            bad_reg <= out_last ? 1'b0 : (bad_reg | status);
        end
    end

    // Frames taken in whose final word has not yet gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= '0;
        end
        else
        begin
            frames_reg <= frames_reg + 8'(in_acc && !cmd && last_byte) - 8'(out_acc && out_last);
        end
    end

    // Status stays set until the frame ends
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && bad_reg) |-> status)
        else $error("status dropped within a discarded frame");

    // A frame end only goes out for a frame end taken in
    a_last_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_last) |-> (frames_reg != 8'd0))
        else $error("frame end sent without a matching input frame end");

    // A waiting result word holds until taken
    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)
                             && $stable(status)))
        else $error("waiting result word changed or vanished");

endmodule

bind wep_frame_encapsulator wfe_checker u_wfe_checker (.*);
